### rtl/assert_macros.svh
// assertion macros used by the pointing angle compensation core
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checked only while out of reset
`define PAC_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// checked on every edge, reset included
`define PAC_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

### rtl/pacomp_pkg.sv
// types, constants and the atan table of the pointing compensation datapath
package pacomp_pkg;

  localparam int unsigned VW = 34;
  localparam int unsigned ZW = 33;
  localparam int unsigned MAX_STAGES = 32;

  typedef logic signed [VW-1:0] vec_t;
  typedef logic signed [ZW-1:0] ang_t;
  typedef logic [31:0]          bang_t;

  // cordic gain compensation, q30
  localparam vec_t GAIN_Q30 = 34'sd652032874;

  function automatic ang_t atan_entry(input logic [4:0] idx);
    ang_t v;
    unique case (idx)
      5'd0:  v = 33'sh020000000;
      5'd1:  v = 33'sh012E4051D;
      5'd2:  v = 33'sh009FB385B;
      5'd3:  v = 33'sh0051111D4;
      5'd4:  v = 33'sh0028B0D43;
      5'd5:  v = 33'sh00145D7E1;
      5'd6:  v = 33'sh000A2F61E;
      5'd7:  v = 33'sh000517C55;
      5'd8:  v = 33'sh00028BE53;
      5'd9:  v = 33'sh000145F2E;
      5'd10: v = 33'sh0000A2F98;
      5'd11: v = 33'sh0000517CC;
      5'd12: v = 33'sh000028BE6;
      5'd13: v = 33'sh0000145F3;
      5'd14: v = 33'sh00000A2F9;
      5'd15: v = 33'sh00000517C;
      5'd16: v = 33'sh0000028BE;
      5'd17: v = 33'sh00000145F;
      5'd18: v = 33'sh000000A2F;
      5'd19: v = 33'sh000000517;
      5'd20: v = 33'sh00000028B;
      5'd21: v = 33'sh000000145;
      5'd22: v = 33'sh0000000A2;
      5'd23: v = 33'sh000000051;
      5'd24: v = 33'sh000000028;
      5'd25: v = 33'sh000000014;
      5'd26: v = 33'sh00000000A;
      5'd27: v = 33'sh000000005;
      5'd28: v = 33'sh000000002;
      5'd29: v = 33'sh000000001;
      5'd30: v = 33'sh000000000;
      5'd31: v = 33'sh000000000;
    endcase
    return v;
  endfunction

endpackage

### rtl/pacomp_cordic_rot.sv
// pipelined rotation-mode cordic: binary angle in, q30 sine and cosine out
module pacomp_cordic_rot #(
  parameter int unsigned NS = 16
) (
  input  logic              clk,
  input  pacomp_pkg::bang_t bang,
  output pacomp_pkg::vec_t  sin_q,
  output pacomp_pkg::vec_t  cos_q
);
  import pacomp_pkg::*;

  vec_t  x_r   [0:NS];
  vec_t  y_r   [0:NS];
  ang_t  z_r   [0:NS];
  logic  neg_r [0:NS];
  vec_t  sin_r;
  vec_t  cos_r;
  logic  fold;
  bang_t a_fold;

  // second and third quadrant: rotate by half a turn, negate at the end
  assign fold   = bang[31] ^ bang[30];
  assign a_fold = {bang[31] ^ fold, bang[30:0]};

  always_ff @(posedge clk) begin
    x_r[0]   <= GAIN_Q30;
    y_r[0]   <= '0;
    z_r[0]   <= ang_t'(signed'(a_fold));
    neg_r[0] <= fold;
  end

  for (genvar i = 0; i < NS; i++) begin : g_stage
    always_ff @(posedge clk) begin
      if (!z_r[i][ZW-1]) begin
        x_r[i+1] <= x_r[i] - (y_r[i] >>> i);
        y_r[i+1] <= y_r[i] + (x_r[i] >>> i);
        z_r[i+1] <= z_r[i] - atan_entry(5'(i));
      end else begin
        x_r[i+1] <= x_r[i] + (y_r[i] >>> i);
        y_r[i+1] <= y_r[i] - (x_r[i] >>> i);
        z_r[i+1] <= z_r[i] + atan_entry(5'(i));
      end
      neg_r[i+1] <= neg_r[i];
    end
  end

  always_ff @(posedge clk) begin
    sin_r <= neg_r[NS] ? -y_r[NS] : y_r[NS];
    cos_r <= neg_r[NS] ? -x_r[NS] : x_r[NS];
  end

  assign sin_q = sin_r;
  assign cos_q = cos_r;

endmodule

### rtl/pacomp_cordic_vec.sv
// pipelined vectoring-mode cordic: atan2 as binary angle and scaled magnitude
module pacomp_cordic_vec #(
  parameter int unsigned NS = 16
) (
  input  logic             clk,
  input  pacomp_pkg::vec_t x_in,
  input  pacomp_pkg::vec_t y_in,
  output pacomp_pkg::ang_t ang,
  output pacomp_pkg::vec_t mag
);
  import pacomp_pkg::*;

  vec_t x_r [0:NS];
  vec_t y_r [0:NS];
  ang_t z_r [0:NS];

  always_ff @(posedge clk) begin
    x_r[0] <= x_in;
    y_r[0] <= y_in;
    z_r[0] <= '0;
  end

  for (genvar i = 0; i < NS; i++) begin : g_stage
    always_ff @(posedge clk) begin
      if (!y_r[i][VW-1]) begin
        x_r[i+1] <= x_r[i] + (y_r[i] >>> i);
        y_r[i+1] <= y_r[i] - (x_r[i] >>> i);
        z_r[i+1] <= z_r[i] + atan_entry(5'(i));
      end else begin
        x_r[i+1] <= x_r[i] - (y_r[i] >>> i);
        y_r[i+1] <= y_r[i] + (x_r[i] >>> i);
        z_r[i+1] <= z_r[i] - atan_entry(5'(i));
      end
    end
  end

  assign ang = z_r[NS];
  assign mag = x_r[NS];

endmodule

### rtl/pointing_angle_compensation_core.sv
// top level of the pointing angle compensation pipeline
//
//  port group   | direction | transfer happens when
//  -------------+-----------+-------------------------------------------
//  in_*, start  | input     | start high and busy low at a clock edge
//  out_*        | output    | out_valid high, held for one cycle only
//  apb          | input     | psel, penable, pwrite and pready all high
//
// a new sample can be taken every cycle; busy is always low
// out_valid follows accept through a valid pipe as deep as the datapath,
// set by the sine/cosine cordic chain and the two vectoring chains in series
// rst_n is synchronous and clears the valid pipe and the two registers
// the result side has no backpressure: each result is shown for one cycle
`include "assert_macros.svh"

module pointing_angle_compensation_core #(
  parameter int unsigned CORDIC_STAGES = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  logic signed [16:0] in_platform_azimuth,
  input  logic signed [15:0] in_platform_roll,
  input  logic signed [15:0] in_platform_pitch,
  input  logic signed [16:0] in_target_azimuth,
  input  logic signed [14:0] in_target_elevation,
  output logic               out_valid,
  output logic signed [14:0] out_azimuth_comp,
  output logic signed [14:0] out_elevation_comp,
  output logic               out_x_zero_flag,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [2:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);
  import pacomp_pkg::*;

  localparam int unsigned NS  = (CORDIC_STAGES > MAX_STAGES) ? MAX_STAGES : CORDIC_STAGES;
  localparam int unsigned LAT = 3 * NS + 16;
  localparam int unsigned NLANE = 6;

  localparam int unsigned LN_TAZ = 0;
  localparam int unsigned LN_TEL = 1;
  localparam int unsigned LN_YAW = 2;
  localparam int unsigned LN_PIT = 3;
  localparam int unsigned LN_ROL = 4;
  localparam int unsigned LN_TLT = 5;

  localparam logic REG_MOUNT_TILT  = 1'b0;
  localparam logic REG_ELEV_OFFSET = 1'b1;

  localparam logic [16:0] TURN_MUL  = 17'd119304;
  localparam logic [10:0] FRAC_MUL  = 11'd1456;
  localparam logic [25:0] FRAC_RND  = 26'd1125;
  localparam logic [25:0] RECIP_MUL = 26'd61083980;

  typedef struct packed {
    logic xzero;
    logic yneg;
  } az_flag_t;

  function automatic logic [15:0] turn_mod(input logic signed [16:0] h);
    logic signed [18:0] s;
    logic [17:0]        u;
    logic [17:0]        d;
    s = 19'(h) + 19'sd72000;
    u = s[17:0];
    priority if (u >= 18'd108000) d = u - 18'd108000;
    else if (u >= 18'd72000)      d = u - 18'd72000;
    else if (u >= 18'd36000)      d = u - 18'd36000;
    else                          d = u;
    return d[15:0];
  endfunction

  function automatic logic [14:0] frac_div(input logic [25:0] v);
    logic [50:0] p;
    p = 51'(v[25:1]) * 51'(RECIP_MUL);
    return p[50:36];
  endfunction

  function automatic vec_t qmul(input vec_t a, input vec_t b);
    logic signed [2*VW-1:0] p;
    p = a * b;
    return p[VW+29:30];
  endfunction

  // configuration registers
  logic               cfg_wr;
  logic signed [14:0] mount_tilt_r;
  logic signed [14:0] elev_offset_r;

  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite & pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mount_tilt_r  <= -15'sd1500;
      elev_offset_r <= -15'sd750;
    end else if (cfg_wr) begin
      unique case (paddr[2])
        REG_MOUNT_TILT:  mount_tilt_r  <= pwdata[14:0];
        REG_ELEV_OFFSET: elev_offset_r <= pwdata[14:0];
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      REG_MOUNT_TILT:  prdata = 32'(mount_tilt_r);
      REG_ELEV_OFFSET: prdata = 32'(elev_offset_r);
    endcase
  end

  // valid pipe
  logic           accept;
  logic [LAT:1]   vld_r;

  assign busy   = 1'b0;
  assign accept = start & ~busy;

  always_ff @(posedge clk) begin
    if (!rst_n) vld_r <= '0;
    else        vld_r <= {vld_r[LAT-1:1], accept};
  end

  // angle to binary angle, four stages
  logic signed [16:0] ang_in [0:NLANE-1];
  logic [15:0]        rmod_r [0:NLANE-1];
  logic [31:0]        p1_r   [0:NLANE-1];
  logic [25:0]        v_r    [0:NLANE-1];
  logic [31:0]        p1d_r  [0:NLANE-1];
  logic [14:0]        q_r    [0:NLANE-1];
  bang_t              bang_r [0:NLANE-1];

  always_comb begin
    ang_in[LN_TAZ] = in_target_azimuth;
    ang_in[LN_TEL] = 17'(in_target_elevation);
    ang_in[LN_YAW] = in_platform_azimuth;
    ang_in[LN_PIT] = 17'(in_platform_pitch);
    ang_in[LN_ROL] = 17'(in_platform_roll);
    ang_in[LN_TLT] = 17'(mount_tilt_r);
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k < NLANE; k++) begin
      rmod_r[k] <= turn_mod(ang_in[k]);
      p1_r[k]   <= 32'(rmod_r[k]) * 32'(TURN_MUL);
      v_r[k]    <= 26'(rmod_r[k]) * 26'(FRAC_MUL) + FRAC_RND;
      p1d_r[k]  <= p1_r[k];
      q_r[k]    <= frac_div(v_r[k]);
      bang_r[k] <= p1d_r[k] + 32'(q_r[k]);
    end
  end

  // sine and cosine of every angle
  vec_t sn [0:NLANE-1];
  vec_t cs [0:NLANE-1];

  for (genvar k = 0; k < NLANE; k++) begin : g_lane
    pacomp_cordic_rot #(.NS(NS)) u_rot (
      .clk   (clk),
      .bang  (bang_r[k]),
      .sin_q (sn[k]),
      .cos_q (cs[k])
    );
  end

  // line of sight vector and the rotation chain
  vec_t x1_r, y1_r, z1_r;
  vec_t sy1_r, cy1_r, sp1_r, cp1_r, sr1_r, cr1_r, st1_r, ct1_r;
  vec_t x2_r, y2_r, z2_r;
  vec_t np2_r, cp2_r, sr2_r, cr2_r, st2_r, ct2_r;
  vec_t x3_r, y3_r, z3_r;
  vec_t sr3_r, cr3_r, st3_r, ct3_r;
  vec_t x4_r, y4_r, z4_r;
  vec_t st4_r, ct4_r;
  vec_t x5_r, y5_r, z5_r;

  always_ff @(posedge clk) begin
    x1_r  <= qmul(cs[LN_TEL], sn[LN_TAZ]);
    y1_r  <= qmul(cs[LN_TEL], cs[LN_TAZ]);
    z1_r  <= sn[LN_TEL];
    sy1_r <= sn[LN_YAW];
    cy1_r <= cs[LN_YAW];
    sp1_r <= sn[LN_PIT];
    cp1_r <= cs[LN_PIT];
    sr1_r <= sn[LN_ROL];
    cr1_r <= cs[LN_ROL];
    st1_r <= sn[LN_TLT];
    ct1_r <= cs[LN_TLT];

    // yaw
    x2_r  <= qmul(cy1_r, x1_r) - qmul(sy1_r, y1_r);
    y2_r  <= qmul(sy1_r, x1_r) + qmul(cy1_r, y1_r);
    z2_r  <= z1_r;
    np2_r <= -sp1_r;
    cp2_r <= cp1_r;
    sr2_r <= sr1_r;
    cr2_r <= cr1_r;
    st2_r <= st1_r;
    ct2_r <= ct1_r;

    // negated pitch
    x3_r  <= x2_r;
    y3_r  <= qmul(cp2_r, y2_r) - qmul(np2_r, z2_r);
    z3_r  <= qmul(np2_r, y2_r) + qmul(cp2_r, z2_r);
    sr3_r <= sr2_r;
    cr3_r <= cr2_r;
    st3_r <= st2_r;
    ct3_r <= ct2_r;

    // roll about y
    x4_r  <= qmul(cr3_r, x3_r) + qmul(sr3_r, z3_r);
    y4_r  <= y3_r;
    z4_r  <= qmul(cr3_r, z3_r) - qmul(sr3_r, x3_r);
    st4_r <= st3_r;
    ct4_r <= ct3_r;

    // axis swap folded into the mount tilt about y
    x5_r  <= qmul(ct4_r, y4_r) + qmul(st4_r, z4_r);
    y5_r  <= -x4_r;
    z5_r  <= qmul(ct4_r, z4_r) - qmul(st4_r, y4_r);
  end

  // azimuth and horizontal magnitude
  logic     x_neg;
  vec_t     ax, ay;
  az_flag_t flag_now;
  ang_t     ang_a;
  vec_t     mag_a;
  ang_t     ang_b;
  vec_t     mag_b;

  assign x_neg          = x5_r[VW-1];
  assign ax             = x_neg ? -x5_r : x5_r;
  assign ay             = x_neg ? -y5_r : y5_r;
  assign flag_now.xzero = (x5_r == '0);
  assign flag_now.yneg  = y5_r[VW-1];

  pacomp_cordic_vec #(.NS(NS)) u_vec_az (
    .clk  (clk),
    .x_in (ax),
    .y_in (ay),
    .ang  (ang_a),
    .mag  (mag_a)
  );

  // magnitude must come from the unmirrored y
  pacomp_cordic_vec #(.NS(NS)) u_vec_mag (
    .clk  (clk),
    .x_in (ax),
    .y_in (y5_r),
    .ang  (ang_b),
    .mag  (mag_b)
  );

  vec_t     zd_r [1:NS+2];
  ang_t     ad_r [1:NS+2];
  az_flag_t fd_r [1:2*NS+3];
  vec_t     hyp_r;

  always_ff @(posedge clk) begin
    zd_r[1] <= z5_r;
    for (int j = 1; j < NS + 2; j++) zd_r[j+1] <= zd_r[j];
    ad_r[1] <= ang_a;
    for (int j = 1; j < NS + 2; j++) ad_r[j+1] <= ad_r[j];
    fd_r[1] <= flag_now;
    for (int j = 1; j < 2 * NS + 3; j++) fd_r[j+1] <= fd_r[j];
    hyp_r <= qmul(mag_b, GAIN_Q30);
  end

  // elevation against the horizontal
  ang_t ang_e;
  vec_t mag_e;
  ang_t ang_spare;

  assign ang_spare = ang_b;

  pacomp_cordic_vec #(.NS(NS)) u_vec_el (
    .clk  (clk),
    .x_in (hyp_r),
    .y_in (zd_r[NS+2]),
    .ang  (ang_e),
    .mag  (mag_e)
  );

  // scale azimuth to hundredths and elevation to fiftieths of a degree, clamp
  logic signed [49:0] pa_r;
  logic signed [49:0] pe_r;
  az_flag_t           fe_r;
  logic signed [49:0] pa_rnd, pe_rnd;
  logic signed [17:0] az_w, el_w;
  logic signed [14:0] az_nxt, el_nxt;
  logic signed [14:0] az_r, el_r;
  logic               xz_r;

  always_ff @(posedge clk) begin
    pa_r <= 50'(ad_r[NS+2]) * 50'sd36000;
    pe_r <= 50'(ang_e) * 50'sd18000;
    fe_r <= fd_r[2*NS+3];
  end

  always_comb begin
    pa_rnd = pa_r + 50'sd2147483648;
    pe_rnd = pe_r + 50'sd2147483648;
    az_w   = signed'(pa_rnd[49:32]);
    el_w   = signed'(pe_rnd[49:32]) + 18'(elev_offset_r);
    if (fe_r.xzero)               az_nxt = fe_r.yneg ? -15'sd9000 : 15'sd9000;
    else if (az_w > 18'sd9000)    az_nxt = 15'sd9000;
    else if (az_w < -18'sd9000)   az_nxt = -15'sd9000;
    else                          az_nxt = 15'(az_w);
    if (el_w > 18'sd13500)        el_nxt = 15'sd13500;
    else if (el_w < -18'sd13500)  el_nxt = -15'sd13500;
    else                          el_nxt = 15'(el_w);
  end

  always_ff @(posedge clk) begin
    az_r <= az_nxt;
    el_r <= el_nxt;
    xz_r <= fe_r.xzero;
  end

  assign out_valid          = vld_r[LAT];
  assign out_azimuth_comp   = az_r;
  assign out_elevation_comp = el_r;
  // the angle of the magnitude lane and the final magnitude are not needed
  assign out_x_zero_flag    = xz_r | ((ang_spare == '0) & (mag_e == '0) & 1'b0);

  logic az_at_limit;
  logic el_in_range;

  assign az_at_limit = (out_azimuth_comp == 15'sd9000) || (out_azimuth_comp == -15'sd9000);
  assign el_in_range = (out_elevation_comp <= 15'sd13500) &&
                       (out_elevation_comp >= -15'sd13500);

  `PAC_ASSERT(a_latency, (start && !busy) |-> ##LAT out_valid, "accepted item lost in pipe")
  `PAC_ASSERT(a_no_spurious, out_valid |-> $past(start && !busy, LAT), "result without item")
  `PAC_ASSERT(a_flag_sat, (out_valid && out_x_zero_flag) |-> az_at_limit, "zero x not saturated")
  `PAC_ASSERT(a_el_range, out_valid |-> el_in_range, "elevation out of range")
  `PAC_ASSERT_ALWAYS(a_rst_clear, !rst_n |=> !out_valid, "valid pipe not cleared")

endmodule
